### hdl/sde_pkg.sv
// Shared types, constants and round functions of the SHA-256 digest engine.
`timescale 1ns / 1ps

package sde_pkg;

   localparam int WordW      = 32;
   localparam int SchedDepth = 16;
   localparam int SchedAddrW = $clog2(SchedDepth);
   localparam int HashWords  = 8;
   localparam int HashIdxW   = $clog2(HashWords);
   localparam int PosW       = 6;
   localparam int CycW       = 7;

   // Sequencer points inside one compression
   localparam logic [CycW-1:0] CycRoundFirst = 7'd2;
   localparam logic [CycW-1:0] CycWbFirst    = 7'd17;
   localparam logic [CycW-1:0] CycWordLast   = 7'd64;
   localparam logic [CycW-1:0] CycLast       = 7'd65;

   localparam logic [7:0]      PadByte       = 8'h80;
   localparam logic [PosW-1:0] LenPosFirst   = 6'd56;

   typedef logic [WordW-1:0]                 word_type;
   typedef logic [HashWords-1:0][WordW-1:0] hash_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FOLD  = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } sde_state_type;

   // Compression control from the sequencer
   typedef struct packed {
      logic            active;
      logic [CycW-1:0] cyc;
   } sde_ctl_type;

   // One write into the block buffer
   typedef struct packed {
      logic                  en;
      logic [SchedAddrW-1:0] addr;
      word_type              data;
   } sde_wr_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordW - n));
   endfunction

   function automatic word_type big_sig0(input word_type x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sig0(input word_type x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic word_type iv_word(input logic [HashIdxW-1:0] i);
      case (i)
         3'd0:    iv_word = 32'h6a09e667;
         3'd1:    iv_word = 32'hbb67ae85;
         3'd2:    iv_word = 32'h3c6ef372;
         3'd3:    iv_word = 32'ha54ff53a;
         3'd4:    iv_word = 32'h510e527f;
         3'd5:    iv_word = 32'h9b05688c;
         3'd6:    iv_word = 32'h1f83d9ab;
         3'd7:    iv_word = 32'h5be0cd19;
         default: iv_word = '0;
      endcase
   endfunction

   function automatic word_type round_k(input logic [5:0] r);
      case (r)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = '0;
      endcase
   endfunction

endpackage

### hdl/sde_req_if.sv
// Message byte channel: valid/ready with the byte payload.
`timescale 1ns / 1ps

interface sde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_item;
   logic       no_data;

   modport source (output valid, data_byte, final_item, no_data, input ready);
   modport sink   (input valid, data_byte, final_item, no_data, output ready);
endinterface

### hdl/sde_rsp_if.sv
// Digest word channel: valid/ready with the digest payload.
`timescale 1ns / 1ps

interface sde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        word_last;
   logic        length_overflow;

   modport source (output valid, digest_word, word_last, length_overflow, input ready);
   modport sink   (input valid, digest_word, word_last, length_overflow, output ready);
endinterface

### hdl/sde_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module sde_ram #(
   parameter int Width = sde_pkg::WordW,
   parameter int Depth = sde_pkg::SchedDepth
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];

   // Write and read; a read of the entry being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### hdl/sde_sched.sv
// Message schedule: addresses the block buffer and expands words in place.
`timescale 1ns / 1ps

module sde_sched (
   input  logic                                 clock,
   input  sde_pkg::sde_ctl_type                 ctl,
   input  sde_pkg::word_type                    rd_data_a,
   input  sde_pkg::word_type                    rd_data_b,
   output logic [sde_pkg::SchedAddrW-1:0]       rd_addr_a,
   output logic [sde_pkg::SchedAddrW-1:0]       rd_addr_b,
   output sde_pkg::sde_wr_type                  wb,
   output sde_pkg::word_type                    w_word
);

   localparam logic [sde_pkg::CycW-1:0] CycBufEnd = 7'(sde_pkg::SchedDepth);
   localparam logic [sde_pkg::CycW-1:0] CycWrapRd = 7'(sde_pkg::SchedDepth - 1);
   localparam logic [sde_pkg::SchedAddrW-1:0] OffsA = 4'd1;
   localparam logic [sde_pkg::SchedAddrW-1:0] OffsB = 4'd9;

   sde_pkg::word_type            w_ff, wm2_ff, prev_ff, w_calc;
   logic [sde_pkg::CycW-1:0]     m_idx;

   // Word m = cyc - 1 is formed from the reads issued last cycle
   assign m_idx = ctl.cyc - 7'd1;

   // Issue reads for word cyc: w[n] while n < 16, else w[n-15], on port A; w[n-7] on port B
   always_comb begin
      if (ctl.cyc < CycBufEnd) begin
         rd_addr_a = ctl.cyc[sde_pkg::SchedAddrW-1:0];
      end else begin
         rd_addr_a = ctl.cyc[sde_pkg::SchedAddrW-1:0] + OffsA;
      end
      // Word 15 slot fetches w[0], the first w[n-16] of the expansion
      if (ctl.cyc == CycWrapRd) begin
         rd_addr_b = '0;
      end else begin
         rd_addr_b = ctl.cyc[sde_pkg::SchedAddrW-1:0] + OffsB;
      end
   end

   // Expand: w[m] = w[m-16] + s0(w[m-15]) + w[m-7] + s1(w[m-2])
   always_comb begin
      if (m_idx < CycBufEnd) begin
         w_calc = rd_data_a;
      end else begin
         w_calc = prev_ff + sde_pkg::small_sig0(rd_data_a) + rd_data_b
                  + sde_pkg::small_sig1(wm2_ff);
      end
   end

   // Write expanded words back over the entry they retire
   always_comb begin
      wb.en   = ctl.active && (ctl.cyc >= sde_pkg::CycWbFirst)
                && (ctl.cyc <= sde_pkg::CycWordLast);
      wb.addr = m_idx[sde_pkg::SchedAddrW-1:0];
      wb.data = w_calc;
   end

   // Hold the last two words and w[m-15] for the next expansion
   always_ff @(posedge clock) begin
      w_ff   <= w_calc;
      wm2_ff <= w_ff;
      if (m_idx == CycWrapRd) begin
         prev_ff <= rd_data_b;
      end else begin
         prev_ff <= rd_data_a;
      end
   end

   assign w_word = w_ff;

endmodule

### hdl/sde_round.sv
// Compression round: working variables a..h, one round per cycle.
`timescale 1ns / 1ps

module sde_round (
   input  logic                 clock,
   input  sde_pkg::sde_ctl_type ctl,
   input  sde_pkg::hash_type    chain,
   input  sde_pkg::word_type    w_word,
   output sde_pkg::hash_type    work
);

   sde_pkg::hash_type  work_ff, work_in;
   sde_pkg::word_type  t1, t2;
   logic [5:0]         r_idx;
   logic [sde_pkg::CycW-1:0] r_full;

   assign r_full = ctl.cyc - sde_pkg::CycRoundFirst;
   assign r_idx  = r_full[5:0];

   // Round sums
   assign t1 = work_ff[7] + sde_pkg::big_sig1(work_ff[4])
               + sde_pkg::choose(work_ff[4], work_ff[5], work_ff[6])
               + sde_pkg::round_k(r_idx) + w_word;
   assign t2 = sde_pkg::big_sig0(work_ff[0])
               + sde_pkg::majority(work_ff[0], work_ff[1], work_ff[2]);

   // Load from the chain at the start, then rotate the variables
   always_comb begin
      work_in = work_ff;
      if (ctl.active) begin
         if (ctl.cyc == '0) begin
            work_in = chain;
         end else if (ctl.cyc >= sde_pkg::CycRoundFirst) begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

### hdl/sha256_digest_engine_unit.sv
// SHA-256 digest engine top level: byte packing, padding, chaining and output.
//
//  Channel  Dir  Payload                                     Transfer when
//  req_ch   in   data_byte[7:0], final_item, no_data         valid & ready
//  rsp_ch   out  digest_word[31:0], word_last, length_overflow valid & ready
//
// The 64th byte of a block starts a compression (schedule fetch lead plus 64
// rounds, one per cycle, limited by the round adder chain) and a fold step;
// req_ch.ready is low meanwhile. A final item adds up to 18 padding-word
// writes (one per cycle through the single buffer write port), one or two
// compressions and eight output words.
// Reset is synchronous; the chain returns to the initial hash, no clearing
// pass. rsp_ch stalls hold the output register; the last word of a digest may
// wait there while the next message is taken.
`timescale 1ns / 1ps

module sha256_digest_engine_unit (
   input logic       clock,
   input logic       reset,
   sde_req_if.sink   req_ch,
   sde_rsp_if.source rsp_ch
);

   localparam logic [sde_pkg::SchedAddrW-1:0] WidxLenHi = 4'd14;
   localparam logic [sde_pkg::SchedAddrW-1:0] WidxLast  = 4'd15;
   localparam logic [sde_pkg::PosW-1:0]       PosLast   = 6'd63;
   localparam logic [sde_pkg::HashIdxW-1:0]   OidxLast  = 3'(sde_pkg::HashWords - 1);

   sde_pkg::sde_state_type              state_ff, state_in;
   logic [sde_pkg::CycW-1:0]            cyc_ff, cyc_in;
   logic [sde_pkg::PosW-1:0]            pos_ff, pos_in;
   logic [23:0]                         acc_ff, acc_in;
   logic [31:0]                         count_ff, count_in;
   logic                                ovf_ff, ovf_in;
   logic                                fin_ff, fin_in;
   logic                                len_done_ff, len_done_in;
   logic                                extra_ff, extra_in;
   logic                                head_ff, head_in;
   logic [sde_pkg::SchedAddrW-1:0]      widx_ff, widx_in;
   logic [sde_pkg::HashIdxW-1:0]        oidx_ff, oidx_in;
   sde_pkg::hash_type                   chain_ff, chain_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   sde_pkg::word_type                   rsp_word_ff, rsp_word_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   logic                                req_fire;
   sde_pkg::sde_ctl_type                ctl;
   sde_pkg::sde_wr_type                 ram_wr, sched_wr;
   logic [sde_pkg::SchedAddrW-1:0]      rd_addr_a, rd_addr_b;
   sde_pkg::word_type                   rd_data_a, rd_data_b, w_word, pad_word;
   sde_pkg::hash_type                   work;

   assign req_ch.ready = (state_ff == sde_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;

   assign ctl.active = (state_ff == sde_pkg::ST_ROUND);
   assign ctl.cyc    = cyc_ff;

   sde_ram #(
      .Width (sde_pkg::WordW),
      .Depth (sde_pkg::SchedDepth)
   ) u_buf (
      .clock     (clock),
      .wr_en     (ram_wr.en),
      .wr_addr   (ram_wr.addr),
      .wr_data   (ram_wr.data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sde_sched u_sched (
      .clock     (clock),
      .ctl       (ctl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wb        (sched_wr),
      .w_word    (w_word)
   );

   sde_round u_round (
      .clock  (clock),
      .ctl    (ctl),
      .chain  (chain_ff),
      .w_word (w_word),
      .work   (work)
   );

   // Padding word for the current slot: marker word, zeros or bit length
   always_comb begin
      if (head_ff) begin
         case (pos_ff[1:0])
            2'd0:    pad_word = {sde_pkg::PadByte, 24'h0};
            2'd1:    pad_word = {acc_ff[7:0], sde_pkg::PadByte, 16'h0};
            2'd2:    pad_word = {acc_ff[15:0], sde_pkg::PadByte, 8'h0};
            2'd3:    pad_word = {acc_ff[23:0], sde_pkg::PadByte};
            default: pad_word = '0;
         endcase
      end else if (!extra_ff && widx_ff == WidxLenHi) begin
         pad_word = {29'h0, count_ff[31:29]};
      end else if (!extra_ff && widx_ff == WidxLast) begin
         pad_word = {count_ff[28:0], 3'h0};
      end else begin
         pad_word = '0;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      fin_in       = fin_ff;
      len_done_in  = len_done_ff;
      extra_in     = extra_ff;
      head_in      = head_ff;
      widx_in      = widx_ff;
      oidx_in      = oidx_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr       = '0;

      case (state_ff)
         sde_pkg::ST_IDLE: begin
            if (req_fire) begin
               // Absorb the byte, store each completed word
               if (!req_ch.no_data) begin
                  acc_in = {acc_ff[15:0], req_ch.data_byte};
                  pos_in = pos_ff + 6'd1;
                  if (count_ff == '1) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + 32'd1;
                  end
                  if (pos_ff[1:0] == 2'b11) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = pos_ff[5:2];
                     ram_wr.data = {acc_ff, req_ch.data_byte};
                  end
               end
               // Arm the padding sequence
               if (req_ch.final_item) begin
                  fin_in   = 1'b1;
                  head_in  = 1'b1;
                  widx_in  = pos_in[5:2];
                  extra_in = (pos_in >= sde_pkg::LenPosFirst);
               end
               if (!req_ch.no_data && pos_ff == PosLast) begin
                  state_in = sde_pkg::ST_ROUND;
                  cyc_in   = '0;
               end else if (req_ch.final_item) begin
                  state_in = sde_pkg::ST_PAD;
               end
            end
         end

         sde_pkg::ST_ROUND: begin
            ram_wr = sched_wr;
            cyc_in = cyc_ff + 7'd1;
            if (cyc_ff == sde_pkg::CycLast) begin
               state_in = sde_pkg::ST_FOLD;
            end
         end

         sde_pkg::ST_FOLD: begin
            for (int i = 0; i < sde_pkg::HashWords; i++) begin
               chain_in[i] = chain_ff[i] + work[i];
            end
            if (!fin_ff) begin
               state_in = sde_pkg::ST_IDLE;
            end else if (len_done_ff) begin
               state_in = sde_pkg::ST_OUT;
               oidx_in  = '0;
            end else begin
               state_in = sde_pkg::ST_PAD;
            end
         end

         sde_pkg::ST_PAD: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = widx_ff;
            ram_wr.data = pad_word;
            head_in     = 1'b0;
            widx_in     = widx_ff + 4'd1;
            if (widx_ff == WidxLast) begin
               state_in = sde_pkg::ST_ROUND;
               cyc_in   = '0;
               if (extra_ff) begin
                  extra_in = 1'b0;
               end else begin
                  len_done_in = 1'b1;
               end
            end
         end

         sde_pkg::ST_OUT: begin
            // Load the next digest word once the output register frees
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[oidx_ff];
               rsp_last_in  = (oidx_ff == OidxLast);
               rsp_ovf_in   = ovf_ff;
               oidx_in      = oidx_ff + 3'd1;
               if (oidx_ff == OidxLast) begin
                  state_in    = sde_pkg::ST_IDLE;
                  pos_in      = '0;
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  fin_in      = 1'b0;
                  len_done_in = 1'b0;
                  for (int i = 0; i < sde_pkg::HashWords; i++) begin
                     chain_in[i] = sde_pkg::iv_word(3'(i));
                  end
               end
            end
         end

         default: begin
            state_in = sde_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sde_pkg::ST_IDLE;
         cyc_ff       <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         len_done_ff  <= 1'b0;
         extra_ff     <= 1'b0;
         head_ff      <= 1'b0;
         widx_ff      <= '0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sde_pkg::HashWords; i++) begin
            chain_ff[i] <= sde_pkg::iv_word(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         cyc_ff       <= cyc_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         fin_ff       <= fin_in;
         len_done_ff  <= len_done_in;
         extra_ff     <= extra_in;
         head_ff      <= head_in;
         widx_ff      <= widx_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.digest_word     = rsp_word_ff;
   assign rsp_ch.word_last       = rsp_last_ff;
   assign rsp_ch.length_overflow = rsp_ovf_ff;

endmodule

### hdl/sde_checker.sv
// Port-level checker for the digest engine, bound to the top level.
`timescale 1ns / 1ps

module sde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_final_item,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_word_last,
   input logic        rsp_length_overflow
);

   // A stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_last) && $stable(rsp_length_overflow))
      else $error("digest word changed while stalled");

   // No message byte is taken while a digest is mid-delivery
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_last |-> !req_ready)
      else $error("input taken during digest delivery");

   // The end of a message stops intake for padding and compression
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_item |=> !req_ready)
      else $error("input still open after final transfer");

   // The overflow flag is the same on every word of one digest
   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_word_last |=>
         !rsp_valid || rsp_length_overflow == $past(rsp_length_overflow))
      else $error("overflow flag changed within a digest");

endmodule

bind sha256_digest_engine_unit sde_checker u_sde_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_final_item      (req_ch.final_item),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_digest_word     (rsp_ch.digest_word),
   .rsp_word_last       (rsp_ch.word_last),
   .rsp_length_overflow (rsp_ch.length_overflow)
);
